// File: hdl/qrs_pkg.sv
// ============================================================================
// qrs_pkg
// shared codes and limits for the quadratic root solver
// ============================================================================
package qrs_pkg;

    // root kind codes
    localparam logic [1:0] KIND_REAL    = 2'd0;
    localparam logic [1:0] KIND_COMPLEX = 2'd1;
    localparam logic [1:0] KIND_SMALL   = 2'd2;

    // register map
    localparam int         LIMIT_W       = 23;
    localparam logic       REG_LIMIT_IDX = 1'b0;
    localparam logic [22:0] LIMIT_RESET  = 23'd4;

    // fixed point
    localparam int FRAC_BITS = 12;

    // saturation bounds of a signed q20.12 word
    localparam logic signed [31:0] Q20_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q20_MIN = 32'sh8000_0000;

endpackage

// File: hdl/qrs_sqrt_cell.sv
// ============================================================================
// qrs_sqrt_cell
// one restoring digit of the integer square root, registered
// ============================================================================
module qrs_sqrt_cell #(
    parameter int ROOT_W = 25,
    parameter int RAD_W  = 50,
    parameter int TAG_W  = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [ROOT_W:0]   in_rem,
    input  logic [ROOT_W-1:0] in_root,
    input  logic [RAD_W-1:0]  in_rad,
    input  logic [TAG_W-1:0]  in_tag,
    output logic              out_valid,
    output logic [ROOT_W:0]   out_rem,
    output logic [ROOT_W-1:0] out_root,
    output logic [RAD_W-1:0]  out_rad,
    output logic [TAG_W-1:0]  out_tag
);

    logic              valid_reg;
    logic [ROOT_W:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [TAG_W-1:0]  tag_reg;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] probe;

    always_comb
    begin
        trial    = {in_rem, in_rad[RAD_W-1:RAD_W-2]};
        probe    = {1'b0, in_root, 2'b01};
        rad_next = {in_rad[RAD_W-3:0], 2'b00};
        if (trial >= probe)
        begin
            rem_next  = (ROOT_W+1)'(trial - probe);
            root_next = {in_root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = trial[ROOT_W:0];
            root_next = {in_root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        rad_reg  <= rad_next;
        tag_reg  <= in_tag;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_rad   = rad_reg;
    assign out_tag   = tag_reg;

endmodule

// File: hdl/qrs_div_cell.sv
// ============================================================================
// qrs_div_cell
// one restoring quotient bit for two lanes sharing a divisor, registered
// ============================================================================
module qrs_div_cell #(
    parameter int REM_W  = 26,
    parameter int WORK_W = 39,
    parameter int TAG_W  = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [REM_W-1:0]  in_dv,
    input  logic [REM_W-1:0]  in_rem_a,
    input  logic [WORK_W-1:0] in_work_a,
    input  logic [REM_W-1:0]  in_rem_b,
    input  logic [WORK_W-1:0] in_work_b,
    input  logic [TAG_W-1:0]  in_tag,
    output logic              out_valid,
    output logic [REM_W-1:0]  out_dv,
    output logic [REM_W-1:0]  out_rem_a,
    output logic [WORK_W-1:0] out_work_a,
    output logic [REM_W-1:0]  out_rem_b,
    output logic [WORK_W-1:0] out_work_b,
    output logic [TAG_W-1:0]  out_tag
);

    logic              valid_reg;
    logic [REM_W-1:0]  dv_reg;
    logic [REM_W-1:0]  rem_a_reg, rem_a_next, rem_b_reg, rem_b_next;
    logic [WORK_W-1:0] work_a_reg, work_a_next, work_b_reg, work_b_next;
    logic [TAG_W-1:0]  tag_reg;
    logic [REM_W:0]    trial_a, trial_b, dv_ext;
    logic              bit_a, bit_b;

    always_comb
    begin
        dv_ext  = {1'b0, in_dv};
        trial_a = {in_rem_a, in_work_a[WORK_W-1]};
        trial_b = {in_rem_b, in_work_b[WORK_W-1]};
        bit_a   = (trial_a >= dv_ext);
        bit_b   = (trial_b >= dv_ext);
        rem_a_next  = bit_a ? REM_W'(trial_a - dv_ext) : trial_a[REM_W-1:0];
        rem_b_next  = bit_b ? REM_W'(trial_b - dv_ext) : trial_b[REM_W-1:0];
        // quotient bits fill in from the bottom as dividend bits leave the top
        work_a_next = {in_work_a[WORK_W-2:0], bit_a};
        work_b_next = {in_work_b[WORK_W-2:0], bit_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        dv_reg     <= in_dv;
        rem_a_reg  <= rem_a_next;
        rem_b_reg  <= rem_b_next;
        work_a_reg <= work_a_next;
        work_b_reg <= work_b_next;
        tag_reg    <= in_tag;
    end

    assign out_valid  = valid_reg;
    assign out_dv     = dv_reg;
    assign out_rem_a  = rem_a_reg;
    assign out_work_a = work_a_reg;
    assign out_rem_b  = rem_b_reg;
    assign out_work_b = work_b_reg;
    assign out_tag    = tag_reg;

endmodule

// File: hdl/quadratic_root_solver.sv
// ============================================================================
// quadratic_root_solver
// pipelined roots of a*x^2 + b*x + c with q12.12 inputs and q20.12 results
// ============================================================================
//
// channel   direction  handshake              word
// --------  ---------  ---------------------  -----------------------------------
// command   in         start high, busy low   coeff_square, coeff_linear, coeff_const
// result    out        done strobe, one cycle root_kind, first_real, second_real,
//                                             imag_mag, clipped
// config    in/out     apb, pready always 1   small_lead_limit at byte address 0
//
// a new word is taken every cycle; busy is never raised
// each word passes through the square root row (COEFF_WIDTH+1 cells) and the
// divider row (COEFF_WIDTH+15 cells) on its way out
// reset clears the valid bits of every stage and loads the limit with its default
// the receiver cannot stall, so results leave on done with no holding stage
//
module quadratic_root_solver #(
    parameter int COEFF_WIDTH = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // command
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COEFF_WIDTH-1:0] coeff_square,
    input  logic signed [COEFF_WIDTH-1:0] coeff_linear,
    input  logic signed [COEFF_WIDTH-1:0] coeff_const,
    // result
    output logic                          done,
    output logic [1:0]                    root_kind,
    output logic signed [31:0]            first_real,
    output logic signed [31:0]            second_real,
    output logic [30:0]                   imag_mag,
    output logic                          clipped,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    import qrs_pkg::*;

    localparam int W       = COEFF_WIDTH;
    localparam int D2_W    = W + 1;              // 2a, signed
    localparam int PROD_W  = 2 * W;              // b*b and a*c
    localparam int DISC_W  = 2 * W + 3;          // b*b - 4ac, signed
    localparam int RAD_W   = 2 * W + 2;          // |discriminant|
    localparam int ROOT_W  = W + 1;              // floor sqrt
    localparam int NUM_W   = W + 2;              // -b +/- s, signed
    localparam int UN_W    = W + 1;              // numerator magnitude
    localparam int REM_W   = W + 2;              // divisor and remainder
    localparam int WORK_W  = W + 15;             // scaled dividend / quotient
    localparam int SAT_W   = (W + 16 > 33) ? W + 16 : 33;
    localparam int CMP_W   = (D2_W > LIMIT_W) ? D2_W : LIMIT_W;
    localparam int STAG_W  = W + D2_W + 2;       // small, dneg, b, 2a
    localparam int DTAG_W  = 4;                  // small, dneg, neg1, neg2
    localparam int LATENCY = 2 * W + 21;

    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(Q20_MAX);
    localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(Q20_MIN);

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [LIMIT_W-1:0] limit_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_LIMIT_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_LIMIT_IDX) ? {(32 - LIMIT_W)'(0), limit_reg} : 32'd0;

    // ------------------------------------------------------------------
    // stage 1: products, 2a and the small lead test
    // ------------------------------------------------------------------
    logic                     accept;
    logic                     s1_valid_reg;
    logic                     s1_small_reg, s1_small_next;
    logic signed [W-1:0]      s1_b_reg;
    logic signed [D2_W-1:0]   s1_d2_reg, s1_d2_next;
    logic signed [PROD_W-1:0] s1_bb_reg, s1_ac_reg;
    logic [D2_W-1:0]          d2_mag;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        s1_d2_next    = {coeff_square, 1'b0};
        d2_mag        = s1_d2_next[D2_W-1] ? D2_W'(-s1_d2_next) : s1_d2_next;
        s1_small_next = (d2_mag == '0) || (CMP_W'(d2_mag) < CMP_W'(limit_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_small_reg <= s1_small_next;
        s1_b_reg     <= coeff_linear;
        s1_d2_reg    <= s1_d2_next;
        s1_bb_reg    <= coeff_linear * coeff_linear;
        s1_ac_reg    <= coeff_square * coeff_const;
    end

    // ------------------------------------------------------------------
    // stage 2: discriminant sign and magnitude
    // ------------------------------------------------------------------
    logic                     s2_valid_reg;
    logic [RAD_W-1:0]         s2_rad_reg, s2_rad_next;
    logic                     s2_dneg_next;
    logic [STAG_W-1:0]        s2_tag_reg;
    logic signed [DISC_W-1:0] bb_ext, ac4_ext, disc_pos, disc_neg;

    always_comb
    begin
        bb_ext       = DISC_W'(s1_bb_reg);
        ac4_ext      = DISC_W'(s1_ac_reg) <<< 2;
        disc_pos     = bb_ext - ac4_ext;
        disc_neg     = ac4_ext - bb_ext;
        s2_dneg_next = disc_pos[DISC_W-1];
        s2_rad_next  = s2_dneg_next ? disc_neg[RAD_W-1:0] : disc_pos[RAD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_rad_reg <= s2_rad_next;
        s2_tag_reg <= {s1_small_reg, s2_dneg_next, s1_b_reg, s1_d2_reg};
    end

    // ------------------------------------------------------------------
    // square root row, one result bit per cell
    // ------------------------------------------------------------------
    logic              sq_valid [ROOT_W+1];
    logic [ROOT_W:0]   sq_rem   [ROOT_W+1];
    logic [ROOT_W-1:0] sq_root  [ROOT_W+1];
    logic [RAD_W-1:0]  sq_rad   [ROOT_W+1];
    logic [STAG_W-1:0] sq_tag   [ROOT_W+1];

    assign sq_valid[0] = s2_valid_reg;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_rad[0]   = s2_rad_reg;
    assign sq_tag[0]   = s2_tag_reg;

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_sqrt
        qrs_sqrt_cell #(
            .ROOT_W (ROOT_W),
            .RAD_W  (RAD_W),
            .TAG_W  (STAG_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[i]),
            .in_rem    (sq_rem[i]),
            .in_root   (sq_root[i]),
            .in_rad    (sq_rad[i]),
            .in_tag    (sq_tag[i]),
            .out_valid (sq_valid[i+1]),
            .out_rem   (sq_rem[i+1]),
            .out_root  (sq_root[i+1]),
            .out_rad   (sq_rad[i+1]),
            .out_tag   (sq_tag[i+1])
        );
    end

    // ------------------------------------------------------------------
    // stage 3: numerators of both lanes
    // lane 1 real part, lane 2 second real part or imaginary part
    // ------------------------------------------------------------------
    logic                   sq_small, sq_dneg;
    logic signed [W-1:0]    sq_b;
    logic signed [D2_W-1:0] sq_d2;
    logic signed [NUM_W-1:0] neg_b, root_ext;
    logic                   s3_valid_reg, s3_small_reg, s3_dneg_reg;
    logic signed [NUM_W-1:0] s3_n1_reg, s3_n1_next, s3_n2_reg, s3_n2_next;
    logic signed [D2_W-1:0] s3_d2_reg;

    always_comb
    begin
        {sq_small, sq_dneg, sq_b, sq_d2} = sq_tag[ROOT_W];
        neg_b      = -NUM_W'(sq_b);
        root_ext   = NUM_W'({1'b0, sq_root[ROOT_W]});
        s3_n1_next = sq_dneg ? neg_b : neg_b + root_ext;
        s3_n2_next = sq_dneg ? root_ext : neg_b - root_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= sq_valid[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        s3_small_reg <= sq_small;
        s3_dneg_reg  <= sq_dneg;
        s3_n1_reg    <= s3_n1_next;
        s3_n2_reg    <= s3_n2_next;
        s3_d2_reg    <= sq_d2;
    end

    // ------------------------------------------------------------------
    // stage 4: scaled dividends n*8192 + |2a| over divisor 2*|2a|,
    // which rounds to nearest with ties away from zero
    // ------------------------------------------------------------------
    logic [NUM_W-1:0]  n1_abs, n2_abs;
    logic [D2_W-1:0]   ud;
    logic              s4_valid_reg;
    logic [REM_W-1:0]  s4_dv_reg;
    logic [WORK_W-1:0] s4_w1_reg, s4_w2_reg, s4_w1_next, s4_w2_next;
    logic [DTAG_W-1:0] s4_tag_reg, s4_tag_next;

    always_comb
    begin
        n1_abs = s3_n1_reg[NUM_W-1] ? NUM_W'(-s3_n1_reg) : s3_n1_reg;
        n2_abs = s3_n2_reg[NUM_W-1] ? NUM_W'(-s3_n2_reg) : s3_n2_reg;
        ud     = s3_d2_reg[D2_W-1] ? D2_W'(-s3_d2_reg) : s3_d2_reg;
        s4_w1_next = WORK_W'({n1_abs[UN_W-1:0], 13'd0}) + WORK_W'(ud);
        s4_w2_next = WORK_W'({n2_abs[UN_W-1:0], 13'd0}) + WORK_W'(ud);
        s4_tag_next = {s3_small_reg,
                       s3_dneg_reg,
                       s3_n1_reg[NUM_W-1] ^ s3_d2_reg[D2_W-1],
                       !s3_dneg_reg && (s3_n2_reg[NUM_W-1] ^ s3_d2_reg[D2_W-1])};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_dv_reg  <= {ud, 1'b0};
        s4_w1_reg  <= s4_w1_next;
        s4_w2_reg  <= s4_w2_next;
        s4_tag_reg <= s4_tag_next;
    end

    // ------------------------------------------------------------------
    // divider row, one quotient bit per cell, both lanes side by side
    // ------------------------------------------------------------------
    logic              dv_valid [WORK_W+1];
    logic [REM_W-1:0]  dv_dv    [WORK_W+1];
    logic [REM_W-1:0]  dv_rem_a [WORK_W+1];
    logic [WORK_W-1:0] dv_w_a   [WORK_W+1];
    logic [REM_W-1:0]  dv_rem_b [WORK_W+1];
    logic [WORK_W-1:0] dv_w_b   [WORK_W+1];
    logic [DTAG_W-1:0] dv_tag   [WORK_W+1];

    assign dv_valid[0] = s4_valid_reg;
    assign dv_dv[0]    = s4_dv_reg;
    assign dv_rem_a[0] = '0;
    assign dv_w_a[0]   = s4_w1_reg;
    assign dv_rem_b[0] = '0;
    assign dv_w_b[0]   = s4_w2_reg;
    assign dv_tag[0]   = s4_tag_reg;

    for (genvar j = 0; j < WORK_W; j++)
    begin : g_div
        qrs_div_cell #(
            .REM_W  (REM_W),
            .WORK_W (WORK_W),
            .TAG_W  (DTAG_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (dv_valid[j]),
            .in_dv      (dv_dv[j]),
            .in_rem_a   (dv_rem_a[j]),
            .in_work_a  (dv_w_a[j]),
            .in_rem_b   (dv_rem_b[j]),
            .in_work_b  (dv_w_b[j]),
            .in_tag     (dv_tag[j]),
            .out_valid  (dv_valid[j+1]),
            .out_dv     (dv_dv[j+1]),
            .out_rem_a  (dv_rem_a[j+1]),
            .out_work_a (dv_w_a[j+1]),
            .out_rem_b  (dv_rem_b[j+1]),
            .out_work_b (dv_w_b[j+1]),
            .out_tag    (dv_tag[j+1])
        );
    end

    // ------------------------------------------------------------------
    // output stage: sign, saturate and pick by kind
    // ------------------------------------------------------------------
    logic                    o_small, o_dneg, o_neg1, o_neg2;
    logic signed [SAT_W-1:0] q1_ext, q2_ext, v1, v2;
    logic signed [31:0]      r1_sat, r2_sat;
    logic                    clip1, clip2, clip_im;
    logic [30:0]             im_sat;

    logic        done_reg;
    logic [1:0]  kind_reg, kind_next;
    logic signed [31:0] first_reg, first_next, second_reg, second_next;
    logic [30:0] imag_reg, imag_next;
    logic        clip_reg, clip_next;

    always_comb
    begin
        {o_small, o_dneg, o_neg1, o_neg2} = dv_tag[WORK_W];
        q1_ext = SAT_W'(dv_w_a[WORK_W]);
        q2_ext = SAT_W'(dv_w_b[WORK_W]);
        v1     = o_neg1 ? -q1_ext : q1_ext;
        v2     = o_neg2 ? -q2_ext : q2_ext;

        clip1  = (v1 > SAT_HI) || (v1 < SAT_LO);
        r1_sat = (v1 > SAT_HI) ? Q20_MAX : ((v1 < SAT_LO) ? Q20_MIN : v1[31:0]);
        clip2  = (v2 > SAT_HI) || (v2 < SAT_LO);
        r2_sat = (v2 > SAT_HI) ? Q20_MAX : ((v2 < SAT_LO) ? Q20_MIN : v2[31:0]);

        // lane 2 is never negative for the imaginary part
        clip_im = (q2_ext > SAT_HI);
        im_sat  = clip_im ? Q20_MAX[30:0] : q2_ext[30:0];

        if (o_small)
        begin
            kind_next   = KIND_SMALL;
            first_next  = '0;
            second_next = '0;
            imag_next   = '0;
            clip_next   = 1'b0;
        end
        else if (o_dneg)
        begin
            kind_next   = KIND_COMPLEX;
            first_next  = r1_sat;
            second_next = r1_sat;
            imag_next   = im_sat;
            clip_next   = clip1 || clip_im;
        end
        else
        begin
            kind_next   = KIND_REAL;
            first_next  = r1_sat;
            second_next = r2_sat;
            imag_next   = '0;
            clip_next   = clip1 || clip2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid[WORK_W];
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        first_reg  <= first_next;
        second_reg <= second_next;
        imag_reg   <= imag_next;
        clip_reg   <= clip_next;
    end

    assign done        = done_reg;
    assign root_kind   = kind_reg;
    assign first_real  = first_reg;
    assign second_real = second_reg;
    assign imag_mag    = imag_reg;
    assign clipped     = clip_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result word without a command word at the pipeline depth");

    a_small_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && root_kind == KIND_SMALL) |->
            (first_real == 0 && second_real == 0 && imag_mag == 0 && !clipped))
        else $error("rejected equation carries non-zero results");

    a_complex_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (done && root_kind == KIND_COMPLEX) |-> (first_real == second_real))
        else $error("complex pair with differing real parts");

    a_real_no_imag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && root_kind == KIND_REAL) |-> (imag_mag == 0))
        else $error("real roots with an imaginary part");
`endif

endmodule

// File: sim/tb_quadratic_root_solver.sv
// ============================================================================
// tb_quadratic_root_solver
// self-checking bench for the quadratic root solver: directed corner words,
// tolerance register sweeps and random coefficient sets, each result checked
// against a behavioural root predictor kept in the bench
// ============================================================================
module tb_quadratic_root_solver;
    timeunit 1ns;
    timeprecision 1ps;
    import qrs_pkg::*;

    localparam int          CW          = 24;
    localparam logic [2:0]  LIMIT_ADDR  = 3'({REG_LIMIT_IDX, 2'b00});
    localparam logic [2:0]  SPARE_ADDR  = 3'd4;    // no register lives here
    localparam int          PIPE_DEPTH  = 2*CW + 21;
    localparam longint      SMAX        = 2147483647;
    localparam longint      SMIN        = -SMAX - 1;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] r1;
        logic signed [31:0] r2;
        logic [30:0]        im;
        logic               clip;
    } roots_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic signed [CW-1:0] coeff_square = '0;
    logic signed [CW-1:0] coeff_linear = '0;
    logic signed [CW-1:0] coeff_const = '0;
    logic                 done;
    logic [1:0]           root_kind;
    logic signed [31:0]   first_real;
    logic signed [31:0]   second_real;
    logic [30:0]          imag_mag;
    logic                 clipped;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // bench copy of the tolerance register
    logic [22:0] lead_limit;
    roots_t      pending_roots[$];
    int          errors = 0;
    int          words_sent = 0;
    int          kind_seen[3] = '{0, 0, 0};
    int          clip_seen = 0;
    bit          steady_stretch = 1'b0;    // no gaps while set

    quadratic_root_solver #(.COEFF_WIDTH(CW)) DUT (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // root predictor
    // ------------------------------------------------------------------
    function automatic longint unsigned int_sqrt(input longint unsigned m);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > m)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (m >= res + bitv)
            begin
                m   = m - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // n*4096/d rounded to nearest, ties away from zero
    function automatic longint q12_div(input longint n, input longint d);
        longint un;
        longint ud;
        longint q;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q  = (un * 8192 + ud) / (2 * ud);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic longint clamp_q20(input longint v, inout logic clip);
        if (v > SMAX)
        begin
            clip = 1'b1;
            return SMAX;
        end
        if (v < SMIN)
        begin
            clip = 1'b1;
            return SMIN;
        end
        return v;
    endfunction

    function automatic roots_t solve_roots(input logic signed [CW-1:0] a_in,
                                           input logic signed [CW-1:0] b_in,
                                           input logic signed [CW-1:0] c_in,
                                           input logic [22:0] limit);
        roots_t r;
        longint a;
        longint b;
        longint c;
        longint two_a;
        longint two_a_mag;
        longint disc;
        longint root_d;
        longint im;
        logic   clip;
        a = a_in;
        b = b_in;
        c = c_in;
        r = '0;
        clip = 1'b0;
        two_a = 2 * a;
        two_a_mag = (two_a < 0) ? -two_a : two_a;
        if (two_a_mag == 0 || two_a_mag < longint'(limit))
        begin
            r.kind = KIND_SMALL;
            return r;
        end
        disc = b * b - 4 * a * c;
        if (disc >= 0)
        begin
            root_d = int_sqrt(disc);
            r.kind = KIND_REAL;
            r.r1 = 32'(clamp_q20(q12_div(-b + root_d, two_a), clip));
            r.r2 = 32'(clamp_q20(q12_div(-b - root_d, two_a), clip));
        end
        else
        begin
            root_d = int_sqrt(-disc);
            im = q12_div(root_d, two_a_mag);
            r.kind = KIND_COMPLEX;
            r.r1 = 32'(clamp_q20(q12_div(-b, two_a), clip));
            r.r2 = r.r1;
            if (im > SMAX)
            begin
                clip = 1'b1;
                im = SMAX;
            end
            r.im = 31'(im);
        end
        r.clip = clip;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checker: every done strobe takes the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        roots_t want;
        if (done)
        begin
            if (pending_roots.size() == 0)
            begin
                $display("%0t: result word with nothing expected, kind %0d", $time, root_kind);
                errors++;
            end
            else
            begin
                want = pending_roots.pop_front();
                if (root_kind !== want.kind)
                begin
                    $display("%0t: root_kind expected %0d actual %0d", $time, want.kind, root_kind);
                    errors++;
                end
                if (first_real !== want.r1)
                begin
                    $display("%0t: first_real expected %0d actual %0d",
                             $time, want.r1, first_real);
                    errors++;
                end
                if (second_real !== want.r2)
                begin
                    $display("%0t: second_real expected %0d actual %0d",
                             $time, want.r2, second_real);
                    errors++;
                end
                if (imag_mag !== want.im)
                begin
                    $display("%0t: imag_mag expected %0d actual %0d", $time, want.im, imag_mag);
                    errors++;
                end
                if (clipped !== want.clip)
                begin
                    $display("%0t: clipped expected %0b actual %0b", $time, want.clip, clipped);
                    errors++;
                end
                if (want.kind <= KIND_SMALL)
                    kind_seen[want.kind]++;
                if (want.clip)
                    clip_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // shared drivers
    // ------------------------------------------------------------------
    // send one coefficient word, sometimes with a random gap in front of it unless steady_stretch is set
    task automatic send_coeffs(input logic signed [CW-1:0] a,
                               input logic signed [CW-1:0] b,
                               input logic signed [CW-1:0] c);
        int gap;
        gap = 0;
        if (!steady_stretch && $urandom_range(99) < 16)
            gap = $urandom_range(2, 1);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start        <= 1'b1;
        coeff_square <= a;
        coeff_linear <= b;
        coeff_const  <= c;
        // accepted on the first rising edge with busy low
        do
            @(posedge clk);
        while (busy);
        pending_roots.push_back(solve_roots(a, b, c, lead_limit));
        words_sent++;
    endtask

    // drop start and let the pipe empty out
    task automatic drain_pipe();
        @(negedge clk);
        start <= 1'b0;
        wait (pending_roots.size() == 0);
        repeat (PIPE_DEPTH + 10) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == LIMIT_ADDR)
            lead_limit = data[22:0];   // upper bits are dropped
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic signed [CW-1:0] rand_coeff();
        return CW'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------
    // corner words under the reset tolerance of 4
    task automatic test_corners();
        steady_stretch = 1'b1;
        send_coeffs(24'sd1, 24'sd0, 24'sd0);          // 2a = 2, below limit
        send_coeffs(24'sd2, 24'sd0, 24'sd0);          // 2a = 4, exactly the limit
        send_coeffs(-24'sd2, 24'sd4096, 24'sd0);
        send_coeffs(24'sd4096, 24'sd8192, 24'sd4096); // double root at -1
        send_coeffs(24'sd4096, 24'sd0, -24'sd16384);  // roots +-2
        send_coeffs(24'sd4096, 24'sd0, 24'sd4096);    // pure imaginary pair
        send_coeffs(-24'sd4096, 24'sd4096, -24'sd8192);
        send_coeffs(24'sd2, 24'sh7FFFFF, 24'sd0);     // one huge real root and one at zero, saturate
        send_coeffs(24'sd2, 24'sh800000, 24'sd0);
        send_coeffs(24'sd2, 24'sd0, 24'sh7FFFFF);     // huge imaginary part
        send_coeffs(-24'sd3, 24'sh7FFFFF, 24'sh7FFFFF);
        send_coeffs(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        send_coeffs(24'sh800000, 24'sh800000, 24'sh800000);
        send_coeffs(24'sh7FFFFF, 24'sh800000, 24'sh800000);
        send_coeffs(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF);
        send_coeffs(24'sh7FFFFF, 24'sd0, -24'sd1);
        send_coeffs(24'sd0, 24'sd4096, 24'sd4096);    // a zero
        send_coeffs(-24'sd1, 24'sd0, 24'sd0);
        steady_stretch = 1'b0;
        drain_pipe();
    endtask

    // tolerance register at its extremes and with junk in unused places
    task automatic test_limit_sweep();
        apb_write(LIMIT_ADDR, 32'd0);
        steady_stretch = 1'b1;
        send_coeffs(24'sd0, 24'sd5, 24'sd7);          // a zero even at limit 0
        send_coeffs(24'sd1, 24'sd5, 24'sd7);
        send_coeffs(-24'sd1, 24'sh800000, 24'sh7FFFFF);
        steady_stretch = 1'b0;
        drain_pipe();
        apb_write(LIMIT_ADDR, 32'hFF7F_FFFF);         // max, upper bits ignored
        send_coeffs(24'sh3FFFFF, 24'sd4096, 24'sd0);  // 2a one short of limit
        send_coeffs(24'sh400000, 24'sd4096, 24'sd0);  // 2a over the limit
        send_coeffs(24'sh7FFFFF, 24'sd0, 24'sd4096);
        send_coeffs(24'sh800000, 24'sd12345, -24'sd999);
        drain_pipe();
        apb_write(SPARE_ADDR, 32'd0);                 // ignored write
        send_coeffs(24'sh3FFFFF, 24'sd1, 24'sd1);
        drain_pipe();
    endtask

    // random words over a few tolerance settings
    task automatic test_random_stream(input int count);
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] c;
        int i;
        int shape;
        for (i = 0; i < count; i++)
        begin
            if (i % 400 == 0)
            begin
                drain_pipe();
                case ((i / 400) % 4)
                    0: apb_write(LIMIT_ADDR, 32'd4);
                    1: apb_write(LIMIT_ADDR, $urandom);
                    2: apb_write(LIMIT_ADDR, $urandom_range(64));
                    default: apb_write(LIMIT_ADDR, 32'd0);
                endcase
            end
            // a long burst with no gaps in the middle of the run
            steady_stretch = (i >= 600 && i < 800);
            shape = $urandom_range(9);
            a = rand_coeff();
            b = rand_coeff();
            c = rand_coeff();
            case (shape)
                0, 1:
                begin
                    // small coefficients, results in normal range
                    a = $signed(CW'($urandom_range(65535))) - 24'sd32768;
                    b = $signed(CW'($urandom_range(131071))) - 24'sd65536;
                    c = $signed(CW'($urandom_range(131071))) - 24'sd65536;
                end
                2:
                begin
                    // a and c of equal sign, leaning towards complex pairs
                    a = $signed(CW'($urandom_range(32767)));
                    c = $signed(CW'($urandom_range(1048575)));
                    b = $signed(CW'($urandom_range(1023))) - 24'sd512;
                    if ($urandom_range(1))
                    begin
                        a = -a;
                        c = -c;
                    end
                end
                3:
                begin
                    // a near the tolerance
                    a = $signed(CW'(lead_limit >> 1)) + $signed(CW'($urandom_range(2))) - 24'sd1;
                    if ($urandom_range(1))
                        a = -a;
                end
                4:  a = $signed(CW'($urandom_range(8))) - 24'sd4;
                default: ;
            endcase
            send_coeffs(a, b, c);
        end
        drain_pipe();
    endtask

    initial
    begin
        lead_limit = LIMIT_RESET;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);
        test_corners();
        test_limit_sweep();
        test_random_stream(1700);
        $display("covered %0d words: %0d real, %0d complex, %0d rejected, %0d saturated",
                 words_sent, kind_seen[0], kind_seen[1], kind_seen[2], clip_seen);
        $display("tolerance swept from zero to full scale, unused address and bits exercised");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // hard stop in case the handshake hangs
    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: quadratic_root_solver.f
hdl/qrs_pkg.sv
hdl/qrs_sqrt_cell.sv
hdl/qrs_div_cell.sv
hdl/quadratic_root_solver.sv
sim/tb_quadratic_root_solver.sv
